### rtl/core/first_fit_allocator_assert.svh
// assertion macros used by the checker file
`ifndef FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_ALLOCATOR_ASSERT_SVH

// property checked outside reset
`define FFA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffa assertion failed");

// property checked at every edge, reset included
`define FFA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ffa assertion failed");

`endif

### rtl/core/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

   localparam int KEY_W  = 32;
   localparam int CMD_W  = 2;
   localparam int PORT_AW = 17;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

endpackage
`default_nettype wire

### rtl/core/ffa_ram.sv
`default_nettype none
module ffa_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 65
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (32'(rd_addr) < DEPTH) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### rtl/core/first_fit_allocator.sv
`default_nettype none
// channel   ports                                            handshake
// item in   req_command, req_var_key, req_request_size      start & !busy
// result    rsp_start_address                                rsp_valid, one-cycle strobe
//
// after reset the S_INIT state writes the initial free range; busy is high meanwhile.
// an item scans the name table entry by entry over its single read port, stopping
// at a hit, then scans free ranges as needed and moves ranges on insert or removal.
// command 3 is dropped at acceptance. results are never held off.
module first_fit_allocator #(
   parameter int HEAP_WORDS = 65536,
   parameter int NAME_SLOTS = 64,
   parameter int FREE_SLOTS = 65
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ffa_pkg::CMD_W-1:0]     req_command,
   input  wire logic [ffa_pkg::KEY_W-1:0]     req_var_key,
   input  wire logic [ffa_pkg::PORT_AW-1:0]   req_request_size,
   output logic                               busy,
   output logic                               rsp_valid,
   output logic [ffa_pkg::PORT_AW-1:0]        rsp_start_address
);
   import ffa_pkg::*;

   localparam int AW     = $clog2(HEAP_WORDS + 2);
   localparam int SW     = ((AW > PORT_AW) ? AW : PORT_AW) + 1;
   localparam int NIDX_W = $clog2(NAME_SLOTS);
   localparam int FIDX_W = $clog2(FREE_SLOTS);
   localparam int FCNT_W = $clog2(FREE_SLOTS + 1);
   localparam int NREC_W = KEY_W + 2 * AW;
   localparam int FREC_W = 2 * AW;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_NRD, S_NCMP, S_DISP, S_ARD, S_ACMP, S_DRD, S_DWR,
      S_FRD, S_FCMP, S_FRES, S_URD, S_UWR, S_NWR
   } state_type;

   state_type             state_ff;
   logic [CMD_W-1:0]      cmd_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [PORT_AW-1:0]    size_ff;
   logic [NIDX_W-1:0]     ncnt_ff, slot_ff, free_idx_ff;
   logic [FCNT_W-1:0]     fcnt_ff, count_ff, pos_ff;
   logic                  found_ff, have_free_ff;
   logic [AW-1:0]         rec_first_ff, rec_last_ff, s_ff, e_ff;
   logic [AW-1:0]         prev_first_ff, prev_last_ff, nxt_first_ff, nxt_last_ff;
   logic [NAME_SLOTS-1:0] used_ff;
   logic                  rsp_valid_ff;
   logic [PORT_AW-1:0]    rsp_addr_ff;

   logic [NREC_W-1:0]     n_rdata, n_wdata;
   logic                  n_we;
   logic [FREC_W-1:0]     f_rdata, f_wdata;
   logic                  f_we;
   logic [FIDX_W-1:0]     f_waddr, f_raddr;
   logic [FCNT_W-1:0]     fcnt_dec;

   logic [KEY_W-1:0]      nr_key;
   logic [AW-1:0]         nr_first, nr_last, fr_first, fr_last;
   logic [SW-1:0]         len_w, sum_w, size_w;
   logic                  fits, carve_empty, mp, mn, name_hit;

   assign {nr_key, nr_first, nr_last} = n_rdata;
   assign {fr_first, fr_last}         = f_rdata;
   assign size_w      = SW'(size_ff);
   assign len_w       = SW'(fr_last) - SW'(fr_first) + SW'(1);
   assign sum_w       = SW'(fr_first) + size_w;
   assign fits        = len_w >= size_w;
   assign carve_empty = sum_w > SW'(fr_last);
   assign mp = (fcnt_ff != '0) && (SW'(prev_last_ff) + SW'(1) == SW'(s_ff));
   assign mn = (fcnt_ff < count_ff) && (SW'(e_ff) + SW'(1) == SW'(nxt_first_ff));
   assign name_hit = used_ff[ncnt_ff] && (nr_key == key_ff);
   assign fcnt_dec = fcnt_ff - FCNT_W'(1);

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_start_address = rsp_addr_ff;

   assign n_we    = (state_ff == S_NWR);
   assign n_wdata = {key_ff, rec_first_ff, rec_last_ff};
   assign f_raddr = (state_ff == S_URD && fcnt_ff != '0) ? fcnt_dec[FIDX_W-1:0]
                                                          : fcnt_ff[FIDX_W-1:0];

   always_comb begin
      f_we    = 1'b0;
      f_waddr = fcnt_ff[FIDX_W-1:0];
      f_wdata = f_rdata;
      case (state_ff)
         S_INIT: begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = {AW'(1), AW'(HEAP_WORDS)};
         end
         S_ACMP: begin
            f_we    = fits && !carve_empty;
            f_wdata = {sum_w[AW-1:0], fr_last};
         end
         S_DWR: begin
            f_we    = 1'b1;
            f_waddr = fcnt_dec[FIDX_W-1:0];
         end
         S_FRES: begin
            if (mp) begin
               f_we    = 1'b1;
               f_waddr = fcnt_dec[FIDX_W-1:0];
               f_wdata = mn ? {prev_first_ff, nxt_last_ff} : {prev_first_ff, e_ff};
            end else if (mn) begin
               f_we    = 1'b1;
               f_wdata = {s_ff, nxt_last_ff};
            end
         end
         S_UWR: begin
            f_we = 1'b1;
         end
         S_URD: begin
            f_we    = (fcnt_ff == pos_ff);
            f_wdata = {s_ff, e_ff};
         end
         default: begin
            f_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         S_INIT: begin
            count_ff <= FCNT_W'(1);
            state_ff <= S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd_ff       <= req_command;
               key_ff       <= req_var_key;
               size_ff      <= req_request_size;
               ncnt_ff      <= '0;
               found_ff     <= 1'b0;
               have_free_ff <= 1'b0;
               state_ff     <= (req_command == CMD_ALLOC || req_command == CMD_FREE ||
                                req_command == CMD_QUERY) ? S_NRD : S_IDLE;
            end
         end
         S_NRD: begin
            state_ff <= S_NCMP;
         end
         S_NCMP: begin
            if (name_hit) begin
               found_ff     <= 1'b1;
               slot_ff      <= ncnt_ff;
               rec_first_ff <= nr_first;
               rec_last_ff  <= nr_last;
               state_ff     <= S_DISP;
            end else begin
               if (!used_ff[ncnt_ff] && !have_free_ff) begin
                  have_free_ff <= 1'b1;
                  free_idx_ff  <= ncnt_ff;
               end
               if (ncnt_ff == NIDX_W'(NAME_SLOTS - 1)) begin
                  state_ff <= S_DISP;
               end else begin
                  ncnt_ff  <= ncnt_ff + NIDX_W'(1);
                  state_ff <= S_NRD;
               end
            end
         end
         S_DISP: begin
            fcnt_ff  <= '0;
            state_ff <= S_IDLE;
            case (cmd_ff)
               CMD_QUERY: begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= found_ff ? PORT_AW'(SW'(rec_first_ff)) : '0;
               end
               CMD_ALLOC: begin
                  if (found_ff || have_free_ff) begin
                     slot_ff <= found_ff ? slot_ff : free_idx_ff;
                     if (size_ff == '0) begin
                        rec_first_ff <= '0;
                        rec_last_ff  <= '0;
                        state_ff     <= S_NWR;
                     end else begin
                        state_ff <= S_ARD;
                     end
                  end
               end
               CMD_FREE: begin
                  if (found_ff && rec_first_ff != '0) begin
                     s_ff         <= rec_first_ff;
                     e_ff         <= rec_last_ff;
                     rec_first_ff <= '0;
                     rec_last_ff  <= '0;
                     state_ff     <= S_FRD;
                  end
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
         S_ARD: begin
            if (fcnt_ff == count_ff) begin
               rec_first_ff <= '0;
               rec_last_ff  <= '0;
               state_ff     <= S_NWR;
            end else begin
               state_ff <= S_ACMP;
            end
         end
         S_ACMP: begin
            if (fits) begin
               rec_first_ff <= fr_first;
               rec_last_ff  <= AW'(sum_w - SW'(1));
               if (carve_empty) begin
                  fcnt_ff  <= fcnt_ff + FCNT_W'(1);
                  state_ff <= S_DRD;
               end else begin
                  state_ff <= S_NWR;
               end
            end else begin
               fcnt_ff  <= fcnt_ff + FCNT_W'(1);
               state_ff <= S_ARD;
            end
         end
         S_DRD: begin
            if (fcnt_ff == count_ff) begin
               count_ff <= count_ff - FCNT_W'(1);
               state_ff <= S_NWR;
            end else begin
               state_ff <= S_DWR;
            end
         end
         S_DWR: begin
            fcnt_ff  <= fcnt_ff + FCNT_W'(1);
            state_ff <= S_DRD;
         end
         S_FRD: begin
            state_ff <= (fcnt_ff == count_ff) ? S_FRES : S_FCMP;
         end
         S_FCMP: begin
            if (s_ff < fr_first) begin
               nxt_first_ff <= fr_first;
               nxt_last_ff  <= fr_last;
               state_ff     <= S_FRES;
            end else begin
               prev_first_ff <= fr_first;
               prev_last_ff  <= fr_last;
               fcnt_ff       <= fcnt_ff + FCNT_W'(1);
               state_ff      <= S_FRD;
            end
         end
         S_FRES: begin
            if (mp && mn) begin
               fcnt_ff  <= fcnt_ff + FCNT_W'(1);
               state_ff <= S_DRD;
            end else if (mp || mn) begin
               state_ff <= S_NWR;
            end else if (count_ff < FCNT_W'(FREE_SLOTS)) begin
               pos_ff   <= fcnt_ff;
               fcnt_ff  <= count_ff;
               state_ff <= S_URD;
            end else begin
               state_ff <= S_NWR;
            end
         end
         S_URD: begin
            if (fcnt_ff == pos_ff) begin
               count_ff <= count_ff + FCNT_W'(1);
               state_ff <= S_NWR;
            end else begin
               state_ff <= S_UWR;
            end
         end
         S_UWR: begin
            fcnt_ff  <= fcnt_dec;
            state_ff <= S_URD;
         end
         S_NWR: begin
            used_ff[slot_ff] <= 1'b1;
            state_ff         <= S_IDLE;
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_INIT;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= FCNT_W'(1);
      end
   end

   ffa_ram #(.WIDTH(NREC_W), .DEPTH(NAME_SLOTS)) u_names (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (slot_ff),
      .wr_data (n_wdata),
      .rd_addr (ncnt_ff),
      .rd_data (n_rdata)
   );

   ffa_ram #(.WIDTH(FREC_W), .DEPTH(FREE_SLOTS)) u_free (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );
endmodule
`default_nettype wire

### rtl/core/ffa_checker.sv
`default_nettype none
`include "first_fit_allocator_assert.svh"
module ffa_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic [ffa_pkg::CMD_W-1:0] req_command,
   input wire logic                      rsp_valid
);
   import ffa_pkg::*;

   logic real_cmd;
   assign real_cmd = (req_command == CMD_ALLOC) || (req_command == CMD_FREE) ||
                     (req_command == CMD_QUERY);

   `FFA_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy)
   `FFA_ASSERT(a_accept_goes_busy, clock, reset, (start && !busy && real_cmd) |=> busy)
   `FFA_ASSERT(a_rsp_after_work, clock, reset, rsp_valid |-> ($past(busy) && !busy))
   `FFA_ASSERT(a_rsp_one_cycle, clock, reset, rsp_valid |=> !rsp_valid)
endmodule

bind first_fit_allocator ffa_checker u_ffa_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);
`default_nettype wire
